// File: src/sync_class_length_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// Frame decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_CLASS_LENGTH_FRAME_DECODER_ASSERT_SVH
`define SYNC_CLASS_LENGTH_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication.
`define SCLFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame decoder check failed");

// Next-cycle implication.
`define SCLFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame decoder check failed");

`endif

// File: src/sclfd_pkg.sv
// ----------------------------------------------------------------------------
// Frame decoder package
// Protocol bytes, class codes, error codes, register map and shared types.
// ----------------------------------------------------------------------------
package sclfd_pkg;

	// Frame sync bytes.
	localparam logic [7:0] SYNC_FIRST  = 8'h44;
	localparam logic [7:0] SYNC_SECOND = 8'h57;

	// Frame classes.
	localparam logic [7:0] CLS_DEBUG     = 8'h00;
	localparam logic [7:0] CLS_CONFIRM   = 8'h02;
	localparam logic [7:0] CLS_DISTANCE  = 8'h04;
	localparam logic [7:0] CLS_CENTROID  = 8'h05;
	localparam logic [7:0] CLS_DIRECTION = 8'h06;

	// Error codes reported on last_error.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_SYNC  = 2'd1;
	localparam logic [1:0] ERR_CLASS = 2'd2;

	// Register map: index is paddr[4:3], 64-bit registers at 8-byte strides.
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 64;
	localparam logic [1:0]  REG_NCOUNT  = 2'd0;
	localparam logic [1:0]  REG_ADDR_LO = 2'd1;
	localparam logic [1:0]  REG_ADDR_MD = 2'd2;
	localparam logic [1:0]  REG_ADDR_HI = 2'd3;

	// The neighbor table has twelve 16-bit slots in three 64-bit registers.
	localparam int unsigned NBR_SLOTS  = 12;
	localparam int unsigned NBR_IDX_W  = 4;
	localparam int unsigned NBR_TBL_W  = 192;

	// Parser status for the byte presented at the input.
	typedef struct packed {
		logic sync_err;
		logic frame_end;
	} parse_stat_t;

	// One-cycle result of the neighbor compare sequence.
	typedef struct packed {
		logic done;
		logic match;
	} match_res_t;

endpackage

// File: src/sclfd_rx_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received serial byte per transfer.
// ----------------------------------------------------------------------------
interface sclfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/sclfd_res_if.sv
// ----------------------------------------------------------------------------
// Decoder result channel
// Valid/ready channel that carries the decoder status after each byte.
// ----------------------------------------------------------------------------
interface sclfd_res_if;
	logic        valid;
	logic        ready;
	logic        frame_done;
	logic        table_match;
	logic [31:0] centroid_x_bits;
	logic [31:0] centroid_y_bits;
	logic [31:0] direction_x_bits;
	logic [31:0] direction_y_bits;
	logic [31:0] source_distance_bits;
	logic [15:0] frames_seen;
	logic [15:0] errors_seen;
	logic [1:0]  last_error;

	modport source (
		output valid, input ready,
		output frame_done, output table_match,
		output centroid_x_bits, output centroid_y_bits,
		output direction_x_bits, output direction_y_bits,
		output source_distance_bits,
		output frames_seen, output errors_seen, output last_error
	);
	modport sink (
		input valid, output ready,
		input frame_done, input table_match,
		input centroid_x_bits, input centroid_y_bits,
		input direction_x_bits, input direction_y_bits,
		input source_distance_bits,
		input frames_seen, input errors_seen, input last_error
	);
endinterface

// File: src/sclfd_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks sync, class and length bytes and collects payload bytes into a
// store of 16-bit rows. Flags the out-of-sync and end-of-frame bytes.
// ----------------------------------------------------------------------------
module sclfd_parser
	import sclfd_pkg::*;
#(
	parameter int unsigned MAX_NEIGHBORS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           rx_byte,
	output parse_stat_t          stat,
	output logic [7:0]           cls,
	output logic [63:0]          head_bytes,
	input  logic [$clog2((2 * MAX_NEIGHBORS > 8 ? 2 * MAX_NEIGHBORS : 8) / 2)-1:0] rd_row,
	output logic [15:0]          rd_data
);

	localparam int unsigned STORE_DEPTH = (2 * MAX_NEIGHBORS > 8) ? 2 * MAX_NEIGHBORS : 8;
	localparam int unsigned ROWS        = STORE_DEPTH / 2;
	localparam int unsigned ROW_W       = $clog2(ROWS);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_SYNC1 = 3'd1;
	localparam logic [2:0] PH_SYNC2 = 3'd2;
	localparam logic [2:0] PH_CLASS = 3'd3;
	localparam logic [2:0] PH_LEN   = 3'd4;

	logic [2:0]  phase_q;
	logic [7:0]  cls_q;
	logic [7:0]  len_q;
	logic [7:0]  idx_q;
	logic [15:0] store_q [ROWS];
	logic [8:0]  idx_inc;
	logic        store_wr;
	logic [ROW_W-1:0] wr_row;

	// Status of the byte at the input, valid when it is taken.
	assign idx_inc        = {1'b0, idx_q} + 9'd1;
	assign stat.sync_err  = (phase_q == PH_SYNC1) && (rx_byte != SYNC_SECOND);
	assign stat.frame_end = (phase_q == PH_LEN) && (idx_inc >= {1'b0, len_q});

	// Phase sequencing and header capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cls_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
		end else if (take) begin
			case (phase_q)
				PH_SYNC1: begin
					phase_q <= stat.sync_err ? PH_HUNT : PH_SYNC2;
				end
				PH_SYNC2: begin
					cls_q   <= rx_byte;
					phase_q <= PH_CLASS;
				end
				PH_CLASS: begin
					len_q   <= rx_byte;
					idx_q   <= '0;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					idx_q <= idx_inc[7:0];
					if (stat.frame_end) begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					phase_q <= (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
				end
			endcase
		end
	end

	// Payload store: bytes past the store depth are dropped.
	assign store_wr = take && (phase_q == PH_LEN) && (idx_q < 8'(STORE_DEPTH));
	assign wr_row   = idx_q[ROW_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				store_q[r] <= '0;
			end
		end else if (store_wr) begin
			if (idx_q[0]) begin
				store_q[wr_row][15:8] <= rx_byte;
			end else begin
				store_q[wr_row][7:0] <= rx_byte;
			end
		end
	end

	// Fixed view of the first eight bytes and one selectable row.
	assign cls        = cls_q;
	assign head_bytes = {store_q[3], store_q[2], store_q[1], store_q[0]};
	assign rd_data    = store_q[rd_row];

endmodule

// File: src/sclfd_matcher.sv
// ----------------------------------------------------------------------------
// Neighbor table matcher
// Shared 16-bit comparator that walks the neighbor table one entry a cycle
// against the payload rows and stops at the first mismatch.
// ----------------------------------------------------------------------------
module sclfd_matcher
	import sclfd_pkg::*;
#(
	parameter int unsigned MAX_NEIGHBORS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NBR_IDX_W-1:0]    n_words,
	input  logic [NBR_TBL_W-1:0]    nbr_tbl,
	output logic [$clog2((2 * MAX_NEIGHBORS > 8 ? 2 * MAX_NEIGHBORS : 8) / 2)-1:0] rd_row,
	input  logic [15:0]             rd_data,
	output logic                    busy,
	output match_res_t              res
);

	localparam int unsigned STORE_DEPTH = (2 * MAX_NEIGHBORS > 8) ? 2 * MAX_NEIGHBORS : 8;
	localparam int unsigned ROW_W       = $clog2(STORE_DEPTH / 2);

	logic                 busy_q;
	logic [ROW_W-1:0]     idx_q;
	logic [NBR_IDX_W-1:0] tidx;
	logic [15:0]          tbl_word;
	logic                 hit;
	logic                 last;

	// One compare per cycle on the current entry.
	assign tidx     = NBR_IDX_W'(idx_q);
	assign tbl_word = nbr_tbl[16 * tidx +: 16];
	assign hit      = (rd_data == tbl_word);
	assign last     = ({1'b0, tidx} + 5'd1) == {1'b0, n_words};
	assign rd_row   = idx_q;
	assign busy     = busy_q;

	assign res.done  = busy_q && (!hit || last);
	assign res.match = hit;

	// Entry counter and run flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (res.done) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + ROW_W'(1);
			end
		end
	end

endmodule

// File: src/sync_class_length_frame_decoder.sv
// A byte that does not end a frame goes from its transfer through the publish step into the
// output register; a frame-ending byte passes the decode step first, and a confirmation frame
// also the compare step, where N neighbor entries (at most MAX_NEIGHBORS) are compared on the
// one shared comparator. A byte is taken only in the idle state; the next byte is taken while
// a result waits in the output register. The asynchronous reset clears state, counters, the
// payload store and config registers at once, not the result fields; no clearing pass follows.
// ----------------------------------------------------------------------------
// Sync/class/length frame decoder
// Parses framed serial bytes, decodes completed frames and reports status
// after every byte. Neighbor table and count are written over an APB port.
// ----------------------------------------------------------------------------
`include "sync_class_length_frame_decoder_assert.svh"

module sync_class_length_frame_decoder
	import sclfd_pkg::*;
#(
	parameter int unsigned MAX_NEIGHBORS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	sclfd_rx_if.sink           rx,
	sclfd_res_if.source        res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int unsigned STORE_DEPTH = (2 * MAX_NEIGHBORS > 8) ? 2 * MAX_NEIGHBORS : 8;
	localparam int unsigned ROW_W       = $clog2(STORE_DEPTH / 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEC  = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]           state_q;
	logic [NBR_IDX_W-1:0] ncount_q;
	logic [63:0]          addr_lo_q;
	logic [63:0]          addr_md_q;
	logic [63:0]          addr_hi_q;
	logic [NBR_IDX_W-1:0] n_sat;
	logic                 take;
	logic                 cfg_wr;
	logic [1:0]           reg_idx;
	parse_stat_t          pstat;
	match_res_t           mres;
	logic [7:0]           cls;
	logic [63:0]          head_bytes;
	logic [ROW_W-1:0]     rd_row;
	logic [15:0]          rd_data;
	logic                 m_start;
	logic                 m_busy;
	logic                 out_load;

	logic        done_q;
	logic        ack_q;
	logic [31:0] cx_q;
	logic [31:0] cy_q;
	logic [31:0] dx_q;
	logic [31:0] dy_q;
	logic [31:0] sd_q;
	logic [15:0] frame_cnt_q;
	logic [15:0] err_cnt_q;
	logic [1:0]  err_code_q;
	logic        out_valid_q;

	// Configuration registers.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q  <= '0;
			addr_lo_q <= '0;
			addr_md_q <= '0;
			addr_hi_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NCOUNT:  ncount_q  <= pwdata[NBR_IDX_W-1:0];
				REG_ADDR_LO: addr_lo_q <= pwdata;
				REG_ADDR_MD: addr_md_q <= pwdata;
				REG_ADDR_HI: addr_hi_q <= pwdata;
				default:     ncount_q  <= ncount_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NCOUNT:  prdata = {{(DATA_W - NBR_IDX_W){1'b0}}, ncount_q};
			REG_ADDR_LO: prdata = addr_lo_q;
			REG_ADDR_MD: prdata = addr_md_q;
			REG_ADDR_HI: prdata = addr_hi_q;
			default:     prdata = '0;
		endcase
	end

	// Neighbor count is capped at MAX_NEIGHBORS.
	assign n_sat = (ncount_q > NBR_IDX_W'(MAX_NEIGHBORS)) ? NBR_IDX_W'(MAX_NEIGHBORS) : ncount_q;

	assign rx.ready = (state_q == ST_IDLE);
	assign take     = rx.valid && rx.ready;

	sclfd_parser #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx.rx_byte),
		.stat       (pstat),
		.cls        (cls),
		.head_bytes (head_bytes),
		.rd_row     (rd_row),
		.rd_data    (rd_data)
	);

	assign m_start = (state_q == ST_DEC) && (cls == CLS_CONFIRM) && (n_sat != '0);

	sclfd_matcher #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (m_start),
		.n_words (n_sat),
		.nbr_tbl ({addr_hi_q, addr_md_q, addr_lo_q}),
		.rd_row  (rd_row),
		.rd_data (rd_data),
		.busy    (m_busy),
		.res     (mres)
	);

	// Sequencer: take a byte, decode a finished frame, run the compare, publish.
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			ack_q       <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			sd_q        <= '0;
			frame_cnt_q <= '0;
			err_cnt_q   <= '0;
			err_code_q  <= ERR_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						done_q  <= pstat.frame_end;
						state_q <= pstat.frame_end ? ST_DEC : ST_FIN;
						if (pstat.frame_end) begin
							frame_cnt_q <= frame_cnt_q + 16'd1;
						end
						if (pstat.sync_err) begin
							err_cnt_q  <= err_cnt_q + 16'd1;
							err_code_q <= ERR_SYNC;
						end
					end
				end
				ST_DEC: begin
					state_q <= ST_FIN;
					case (cls)
						CLS_CONFIRM: begin
							if (n_sat == '0) begin
								ack_q <= 1'b1;
							end else begin
								state_q <= ST_CMP;
							end
						end
						CLS_CENTROID: begin
							cx_q <= head_bytes[31:0];
							cy_q <= head_bytes[63:32];
						end
						CLS_DIRECTION: begin
							dx_q <= head_bytes[31:0];
							dy_q <= head_bytes[63:32];
						end
						CLS_DISTANCE: begin
							sd_q <= head_bytes[31:0];
						end
						CLS_DEBUG: begin
							ack_q <= ack_q;
						end
						default: begin
							err_cnt_q  <= err_cnt_q + 16'd1;
							err_code_q <= ERR_CLASS;
						end
					endcase
				end
				ST_CMP: begin
					if (mres.done) begin
						ack_q   <= mres.match;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds one result while the next byte is parsed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.frame_done           <= done_q;
			res.table_match          <= ack_q;
			res.centroid_x_bits      <= cx_q;
			res.centroid_y_bits      <= cy_q;
			res.direction_x_bits     <= dx_q;
			res.direction_y_bits     <= dy_q;
			res.source_distance_bits <= sd_q;
			res.frames_seen          <= frame_cnt_q;
			res.errors_seen          <= err_cnt_q;
			res.last_error           <= err_code_q;
		end
	end

	assign res.valid = out_valid_q;

	// A frame-ending byte always goes through the decode step.
	`SCLFD_ASSERT_NEXT(a_frame_end_decodes, take && pstat.frame_end, state_q == ST_DEC)
	// The comparator runs only while the sequencer waits for it.
	`SCLFD_ASSERT_NOW(a_matcher_in_cmp, m_busy, state_q == ST_CMP)
	// A new result appears only out of the publish step.
	`SCLFD_ASSERT_NOW(a_valid_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN)
	// The frame count moves only on a transferred frame-ending byte.
	`SCLFD_ASSERT_NEXT(a_count_only_on_end, !(take && pstat.frame_end), $stable(frame_cnt_q))

endmodule
